// ===== rtl/core/tcs_pkg.sv =====
// shared types, codes and constants of the text console scrollback engine
package tcs_pkg;

  // default geometry
  localparam int COLUMNS_DEF      = 80;
  localparam int SCREEN_ROWS_DEF  = 25;
  localparam int HISTORY_ROWS_DEF = 512;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // field widths
  localparam int OPCODE_W = 3;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int SROW_W   = 5;
  localparam int SCOL_W   = 7;
  localparam int CROW_W   = 9;
  localparam int CCOL_W   = 7;
  localparam int VIEW_W   = 9;
  localparam int LINES_W  = 9;

  // character and attribute constants
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0a;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0f;

  // opcodes on the input channel
  localparam logic [OPCODE_W-1:0] OP_WRITE_CHAR  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_BACKSPACE   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SCROLL_UP   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SCROLL_DOWN = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR       = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_READ_CELL   = 3'd5;

  // classified command kinds
  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_SCROLL_UP,
    CMD_SCROLL_DOWN,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } tcs_cmd_e;

  // one classified command in the queue
  typedef struct packed {
    tcs_cmd_e            kind;
    logic [CHAR_W-1:0]   ch;
    logic [SROW_W-1:0]   row;
    logic [SCOL_W-1:0]   col;
    logic                rd_in_range;
  } tcs_cmd_t;

  // back end status seen by the front end
  typedef struct packed {
    logic sweeping;
    logic idle;
  } tcs_status_t;

endpackage

// ===== rtl/core/tcs_if.sv =====
// valid/ready channel interfaces for commands in and results out
interface tcs_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcs_pkg::OPCODE_W-1:0]  opcode;
  logic [tcs_pkg::CHAR_W-1:0]    char_code;
  logic [tcs_pkg::SROW_W-1:0]    screen_row;
  logic [tcs_pkg::SCOL_W-1:0]    screen_col;

  modport source (output valid, opcode, char_code, screen_row, screen_col, input ready);
  modport sink   (input valid, opcode, char_code, screen_row, screen_col, output ready);
endinterface

interface tcs_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcs_pkg::CHAR_W-1:0]    cell_char;
  logic [tcs_pkg::ATTR_W-1:0]    cell_attr;
  logic [tcs_pkg::CROW_W-1:0]    cursor_line;
  logic [tcs_pkg::CCOL_W-1:0]    cursor_column;
  logic [tcs_pkg::VIEW_W-1:0]    view_top;
  logic [tcs_pkg::LINES_W-1:0]   lines_used;

  modport source (output valid, cell_char, cell_attr, cursor_line, cursor_column, view_top,
                  lines_used, input ready);
  modport sink   (input valid, cell_char, cell_attr, cursor_line, cursor_column, view_top,
                  lines_used, output ready);
endinterface

// ===== rtl/core/text_console_scrollback_top.sv =====
// top level of the text console scrollback engine
// Text terminal engine with a scrollback store of HISTORY_ROWS x COLUMNS cells
// (character low byte, attribute high byte) and a viewport of SCREEN_ROWS rows.
// Every input transaction yields one result transaction carrying the cursor and
// view; reads also return the addressed cell. A front end decodes transactions
// into a two-entry queue; the back end runs each command through the single
// store port: writes, backspace, scroll and control commands take an address
// step, then a store access; reads add a step for the registered read data.
// After reset and after a clear command the store is swept to blanks one cell
// per cycle; no input transaction is taken during the sweep, while attribute
// writes are taken at any time.
module text_console_scrollback_top #(
  parameter int COLUMNS      = tcs_pkg::COLUMNS_DEF,
  parameter int SCREEN_ROWS  = tcs_pkg::SCREEN_ROWS_DEF,
  parameter int HISTORY_ROWS = tcs_pkg::HISTORY_ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tcs_in_if.sink                     in_i,
  tcs_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [tcs_pkg::ATTR_W-1:0] cfg_wdata_i
);
  import tcs_pkg::*;

  logic [ATTR_W-1:0] attr_q;
  tcs_cmd_t          push_cmd, head_cmd;
  tcs_status_t       bk_status;
  logic              q_push, q_pop, q_full, q_empty;

  // attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // decode
  tcs_front #(
    .COLUMNS     (COLUMNS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .status_i (bk_status),
    .push_o   (q_push),
    .cmd_o    (push_cmd)
  );

  // command queue
  tcs_queue #(
    .DEPTH (QUEUE_DEPTH),
    .T     (tcs_cmd_t)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_cmd),
    .pop_i   (q_pop),
    .data_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // execution
  tcs_back #(
    .COLUMNS      (COLUMNS),
    .SCREEN_ROWS  (SCREEN_ROWS),
    .HISTORY_ROWS (HISTORY_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (!q_empty),
    .cmd_pop_o   (q_pop),
    .attr_i      (attr_q),
    .status_o    (bk_status),
    .out_o       (out_o)
  );

  // no input transaction while the store is swept
  a_no_take_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !bk_status.sweeping)
    else $error("input ready during store sweep");

  // the queue is not drained during a sweep
  a_no_pop_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.sweeping |-> !q_pop)
    else $error("command popped during store sweep");

  // a finished sweep hands over to the idle state
  a_sweep_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(bk_status.sweeping) |-> bk_status.idle)
    else $error("sweep did not end in idle");

endmodule

// ===== rtl/core/tcs_front.sv =====
// front end: accepts input transactions and classifies them into commands
module tcs_front #(
  parameter int COLUMNS     = tcs_pkg::COLUMNS_DEF,
  parameter int SCREEN_ROWS = tcs_pkg::SCREEN_ROWS_DEF
) (
  tcs_in_if.sink               in_i,
  input  logic                 q_full_i,
  input  tcs_pkg::tcs_status_t status_i,
  output logic                 push_o,
  output tcs_pkg::tcs_cmd_t    cmd_o
);
  import tcs_pkg::*;

  // take a transaction when the queue has room and no sweep runs
  assign in_i.ready = !q_full_i && !status_i.sweeping;
  assign push_o     = in_i.valid && in_i.ready;

  // opcode decode
  always_comb begin
    cmd_o.ch          = in_i.char_code;
    cmd_o.row         = in_i.screen_row;
    cmd_o.col         = in_i.screen_col;
    cmd_o.rd_in_range = (32'(in_i.screen_row) < 32'(SCREEN_ROWS)) &&
                        (32'(in_i.screen_col) < 32'(COLUMNS));
    unique case (in_i.opcode)
      OP_WRITE_CHAR: begin
        cmd_o.kind = (in_i.char_code == NEWLINE_CHAR) ? CMD_NEWLINE : CMD_CHAR;
      end
      OP_BACKSPACE:   cmd_o.kind = CMD_BACKSPACE;
      OP_SCROLL_UP:   cmd_o.kind = CMD_SCROLL_UP;
      OP_SCROLL_DOWN: cmd_o.kind = CMD_SCROLL_DOWN;
      OP_CLEAR:       cmd_o.kind = CMD_CLEAR;
      OP_READ_CELL:   cmd_o.kind = CMD_READ;
      default:        cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== rtl/core/tcs_queue.sv =====
// small command queue between front and back end
module tcs_queue #(
  parameter int  DEPTH = tcs_pkg::QUEUE_DEPTH,
  parameter type T     = tcs_pkg::tcs_cmd_t
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  input  logic pop_i,
  output T     data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/tcs_back.sv =====
// back end: cursor and view state, history store, sweep and result register
module tcs_back #(
  parameter int COLUMNS      = tcs_pkg::COLUMNS_DEF,
  parameter int SCREEN_ROWS  = tcs_pkg::SCREEN_ROWS_DEF,
  parameter int HISTORY_ROWS = tcs_pkg::HISTORY_ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcs_pkg::tcs_cmd_t            cmd_i,
  input  logic                         cmd_valid_i,
  output logic                         cmd_pop_o,
  input  logic [tcs_pkg::ATTR_W-1:0]   attr_i,
  output tcs_pkg::tcs_status_t         status_o,
  tcs_out_if.source                    out_o
);
  import tcs_pkg::*;

  localparam int LC_W   = $clog2(HISTORY_ROWS);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int CELLS  = HISTORY_ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = ATTR_W + CHAR_W;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ACCESS,
    ST_RDATA
  } state_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_WRITE,
    ACC_READ,
    ACC_CLEAR
  } access_e;

  state_e              state_q;
  access_e             acc_q, acc_d;
  logic [LC_W-1:0]     lc_q, view_q;
  logic [COL_W-1:0]    col_q;
  logic [ADDR_W-1:0]   addr_q, sweep_cnt_q;
  logic [CELL_W-1:0]   wdata_q, wdata_d, rdata_q;
  logic [ATTR_W-1:0]   sweep_attr_q;
  logic                rd_hit_q;

  logic                out_valid_q;
  logic [CHAR_W-1:0]   out_char_q;
  logic [ATTR_W-1:0]   out_attr_q;
  logic [CROW_W-1:0]   out_crow_q;
  logic [CCOL_W-1:0]   out_ccol_q;
  logic [VIEW_W-1:0]   out_view_q;
  logic [LINES_W-1:0]  out_lines_q;

  logic [CELL_W-1:0]   mem_q [CELLS];
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_addr;
  logic [CELL_W-1:0]   mem_wdata;

  logic [LC_W:0]       lc_inc;
  logic [LC_W-1:0]     lc_nl, view_nl, a_row;
  logic [COL_W-1:0]    a_col;
  logic [ADDR_W-1:0]   cell_addr;
  logic [31:0]         hrow;
  logic                wrap, rd_hit, slot_free, res_load;
  logic [CHAR_W-1:0]   rd_char;
  logic [ATTR_W-1:0]   rd_attr;

  // line opening: count saturates one below the depth, view follows the bottom
  always_comb begin
    lc_inc = {1'b0, lc_q} + 1'b1;
    lc_nl  = (lc_inc >= (LC_W+1)'(HISTORY_ROWS)) ? LC_W'(HISTORY_ROWS - 1) : lc_inc[LC_W-1:0];
    view_nl = (32'(lc_nl) >= 32'(SCREEN_ROWS)) ? LC_W'(32'(lc_nl) - 32'(SCREEN_ROWS)) : view_q;
  end

  assign wrap   = (col_q >= COL_W'(COLUMNS));
  assign hrow   = 32'(view_q) + 32'(cmd_i.row);
  assign rd_hit = cmd_i.rd_in_range && (hrow < 32'(lc_q));

  // cell address of the command at the queue head
  always_comb begin
    case (cmd_i.kind)
      CMD_READ: begin
        a_row = hrow[LC_W-1:0];
        a_col = COL_W'(cmd_i.col);
      end
      CMD_BACKSPACE: begin
        a_row = lc_q - 1'b1;
        a_col = col_q - 1'b1;
      end
      default: begin
        a_row = wrap ? lc_nl - 1'b1 : lc_q - 1'b1;
        a_col = wrap ? '0 : col_q;
      end
    endcase
    cell_addr = ADDR_W'(ADDR_W'(a_row) * ADDR_W'(COLUMNS)) + ADDR_W'(a_col);
  end

  // store access kind and write data of the command at the queue head
  always_comb begin
    wdata_d = {attr_i, cmd_i.ch};
    case (cmd_i.kind)
      CMD_CHAR: acc_d = ACC_WRITE;
      CMD_BACKSPACE: begin
        acc_d   = (col_q != '0) ? ACC_WRITE : ACC_NONE;
        wdata_d = {attr_i, BLANK_CHAR};
      end
      CMD_CLEAR: acc_d = ACC_CLEAR;
      CMD_READ:  acc_d = ACC_READ;
      default:   acc_d = ACC_NONE;
    endcase
  end

  assign slot_free = !out_valid_q || out_o.ready;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign res_load  = slot_free && (((state_q == ST_ACCESS) && (acc_q != ACC_READ)) ||
                                   (state_q == ST_RDATA));

  assign status_o.sweeping = (state_q == ST_SWEEP);
  assign status_o.idle     = (state_q == ST_IDLE);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = wdata_q;
    if (state_q == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_addr  = sweep_cnt_q;
      mem_wdata = {sweep_attr_q, BLANK_CHAR};
    end else if (state_q == ST_ACCESS && slot_free) begin
      mem_we = (acc_q == ACC_WRITE);
      mem_re = (acc_q == ACC_READ) && rd_hit_q;
    end
  end

  // history store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  // read cell, or blank outside the screen or past the lines in use
  assign rd_char = rd_hit_q ? rdata_q[CHAR_W-1:0] : BLANK_CHAR;
  assign rd_attr = rd_hit_q ? rdata_q[CELL_W-1:CHAR_W] : attr_i;

  // sequencer, terminal state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      sweep_cnt_q  <= '0;
      sweep_attr_q <= RESET_ATTR;
      lc_q         <= LC_W'(1);
      view_q       <= '0;
      col_q        <= '0;
      acc_q        <= ACC_NONE;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= res_load || (out_valid_q && !out_o.ready);
      unique case (state_q)
        ST_SWEEP: begin
          sweep_cnt_q <= sweep_cnt_q + 1'b1;
          if (sweep_cnt_q == ADDR_W'(CELLS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid_i) begin
            addr_q   <= cell_addr;
            rd_hit_q <= rd_hit;
            wdata_q  <= wdata_d;
            acc_q    <= acc_d;
            state_q  <= ST_ACCESS;
            unique case (cmd_i.kind)
              CMD_CHAR: begin
                if (wrap) begin
                  lc_q   <= lc_nl;
                  view_q <= view_nl;
                  col_q  <= COL_W'(1);
                end else begin
                  col_q <= col_q + 1'b1;
                end
              end
              CMD_NEWLINE: begin
                lc_q   <= lc_nl;
                view_q <= view_nl;
                col_q  <= '0;
              end
              CMD_BACKSPACE: begin
                if (col_q != '0) begin
                  col_q <= col_q - 1'b1;
                end
              end
              CMD_SCROLL_UP: begin
                if (view_q != '0) begin
                  view_q <= view_q - 1'b1;
                end
              end
              CMD_SCROLL_DOWN: begin
                if (32'(view_q) + 32'(SCREEN_ROWS) < 32'(lc_q)) begin
                  view_q <= view_q + 1'b1;
                end
              end
              CMD_CLEAR: begin
                lc_q         <= LC_W'(1);
                view_q       <= '0;
                col_q        <= '0;
                sweep_attr_q <= attr_i;
              end
              CMD_READ, CMD_NOP: begin
              end
            endcase
          end
        end
        ST_ACCESS: begin
          if (slot_free) begin
            if (acc_q == ACC_READ) begin
              state_q <= ST_RDATA;
            end else begin
              out_char_q  <= '0;
              out_attr_q  <= '0;
              out_crow_q  <= CROW_W'(32'(lc_q) - 32'd1 - 32'(view_q));
              out_ccol_q  <= CCOL_W'(col_q);
              out_view_q  <= VIEW_W'(view_q);
              out_lines_q <= LINES_W'(lc_q);
              if (acc_q == ACC_CLEAR) begin
                sweep_cnt_q <= '0;
                state_q     <= ST_SWEEP;
              end else begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        ST_RDATA: begin
          if (slot_free) begin
            out_char_q  <= rd_char;
            out_attr_q  <= rd_attr;
            out_crow_q  <= CROW_W'(32'(lc_q) - 32'd1 - 32'(view_q));
            out_ccol_q  <= CCOL_W'(col_q);
            out_view_q  <= VIEW_W'(view_q);
            out_lines_q <= LINES_W'(lc_q);
            state_q     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // result channel
  assign out_o.valid         = out_valid_q;
  assign out_o.cell_char     = out_char_q;
  assign out_o.cell_attr     = out_attr_q;
  assign out_o.cursor_line   = out_crow_q;
  assign out_o.cursor_column = out_ccol_q;
  assign out_o.view_top      = out_view_q;
  assign out_o.lines_used    = out_lines_q;

endmodule
